[rtl/core/ocfd_pkg.sv]
// shared types, constants and register map of the overcurrent fault detector
`timescale 1ns / 1ps
`default_nettype none

package ocfd_pkg;

  localparam int TIME_W = 48;
  localparam int FRAC_W = 16;
  localparam int CUR_W  = 15;
  localparam int WIN_W  = 16;
  localparam int OUT_W  = 40;

  // input word kinds carried on tuser
  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_RECOVER = 1'b1;

  // filter coefficients in q16, truncated toward zero
  localparam logic [11:0] COEF_B0 = 12'd3991;
  localparam logic [15:0] COEF_A1 = 16'd61544;

  // floor(p / 100) = (p * ceil(2^31 / 100)) >> 31 for p below 2^24
  localparam logic [24:0] WIN_RECIP = 25'd21474837;
  localparam int          WIN_SHIFT = 31;

  typedef enum logic [2:0] {
    REG_LIMIT   = 3'd0,
    REG_PERCENT = 3'd1,
    REG_TIMEOUT = 3'd2,
    REG_TPS     = 3'd3,
    REG_SENSORS = 3'd4,
    REG_HOMING  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] limit_ma;
    logic [7:0]  window_percent;
    logic [15:0] timeout_ms;
    logic [31:0] ticks_per_second;
    logic        sensors_enabled;
    logic        homing_done;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic add;
    logic timing;
    logic scale;
    logic commit;
  } dp_cmd_t;

endpackage

`default_nettype wire

[rtl/core/ocfd_regs.sv]
// apb configuration registers
`timescale 1ns / 1ps
`default_nettype none

module ocfd_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_psel,
  input  wire logic          cfg_penable,
  input  wire logic          cfg_pwrite,
  input  wire logic [4:0]    cfg_paddr,
  input  wire logic [31:0]   cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  output ocfd_pkg::cfg_t     cfg
);
  import ocfd_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_LIMIT:   cfg_nxt.limit_ma         = cfg_pwdata[15:0];
        REG_PERCENT: cfg_nxt.window_percent   = cfg_pwdata[7:0];
        REG_TIMEOUT: cfg_nxt.timeout_ms       = cfg_pwdata[15:0];
        REG_TPS:     cfg_nxt.ticks_per_second = cfg_pwdata;
        REG_SENSORS: cfg_nxt.sensors_enabled  = cfg_pwdata[0];
        REG_HOMING:  cfg_nxt.homing_done      = cfg_pwdata[0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LIMIT:   cfg_prdata = {16'd0, cfg_r.limit_ma};
      REG_PERCENT: cfg_prdata = {24'd0, cfg_r.window_percent};
      REG_TIMEOUT: cfg_prdata = {16'd0, cfg_r.timeout_ms};
      REG_TPS:     cfg_prdata = cfg_r.ticks_per_second;
      REG_SENSORS: cfg_prdata = {31'd0, cfg_r.sensors_enabled};
      REG_HOMING:  cfg_prdata = {31'd0, cfg_r.homing_done};
      default:     cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.limit_ma         <= 16'd0;
      cfg_r.window_percent   <= 8'd100;
      cfg_r.timeout_ms       <= 16'd0;
      cfg_r.ticks_per_second <= 32'd1000;
      cfg_r.sensors_enabled  <= 1'b0;
      cfg_r.homing_done      <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ocfd_ctrl.sv]
// controller state machine sequencing one word through the datapath
`timescale 1ns / 1ps
`default_nettype none

module ocfd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output ocfd_pkg::dp_cmd_t  cmd
);
  import ocfd_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ADD   = 5'b00010,
    ST_TIME  = 5'b00100,
    ST_SCALE = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd        = '0;
    cmd.load   = accept;
    cmd.add    = (state_r == ST_ADD);
    cmd.timing = (state_r == ST_TIME);
    cmd.scale  = (state_r == ST_SCALE);
    cmd.commit = (state_r == ST_DONE) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_ADD;
      ST_ADD:   state_nxt = ST_TIME;
      ST_TIME:  state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_ADD)
    else $error("accepted word did not start the sequence");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r && state_r == ST_IDLE)
    else $error("committed result not presented");

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_tready)
    else $error("input taken while busy");

endmodule

`default_nettype wire

[rtl/core/ocfd_dp.sv]
// datapath: iir filter, window, persistence timer, fault latch and result register
`timescale 1ns / 1ps
`default_nettype none

module ocfd_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ocfd_pkg::cfg_t                cfg,
  input  wire ocfd_pkg::dp_cmd_t             cmd,
  input  wire logic                          in_chk,
  input  wire logic [ocfd_pkg::CUR_W-1:0]    in_cur,
  input  wire logic [ocfd_pkg::TIME_W-1:0]   in_now,
  output logic [ocfd_pkg::OUT_W-1:0]         out_word
);
  import ocfd_pkg::*;

  localparam int LHS_W = TIME_W + 10;
  localparam int RHS_W = 49;

  // architectural state
  logic [31:0]       filter_r, filter_nxt;
  logic              run_r, run_nxt;
  logic [TIME_W-1:0] start_r, start_nxt;
  logic              latch_r, latch_nxt;
  logic              queued_r, queued_nxt;

  // per word working registers
  logic              chk_r;
  logic [CUR_W-1:0]  cur_r;
  logic [TIME_W-1:0] now_r;
  logic [47:0]       fbp_r;
  logic [26:0]       bx_r;
  logic [23:0]       prod_r;
  logic [WIN_W-1:0]  win_r;
  logic [31:0]       fcand_r;
  logic              above_r;
  logic [TIME_W-1:0] elapsed_r;
  logic [RHS_W-1:0]  rhs_r;
  logic [LHS_W-1:0]  lhs_r;
  logic [OUT_W-1:0]  out_r;

  logic [48:0]       win_prod;
  logic [17:0]       win_q;
  logic [48:0]       fb_sum;
  logic [33:0]       y_sum;
  logic [CUR_W-1:0]  fcand_int;
  logic [31:0]       tps1;
  logic [LHS_W-1:0]  e_ext;
  logic              pass;
  logic              update;
  logic              raised;
  logic [31:0]       fout;
  logic [CUR_W-1:0]  fout_int;

  function automatic logic [CUR_W-1:0] sat_int(input logic [31:0] q);
    logic [15:0] v;
    v = q[31:FRAC_W];
    sat_int = v[15] ? {CUR_W{1'b1}} : v[CUR_W-1:0];
  endfunction

  assign win_prod  = 49'(prod_r) * 49'(WIN_RECIP);
  assign win_q     = win_prod[WIN_SHIFT +: 18];
  assign fb_sum    = 49'(fbp_r) + 49'(16'hFFFF);
  assign y_sum     = 34'(fb_sum[48:FRAC_W]) + 34'(bx_r);
  assign fcand_int = sat_int(fcand_r);
  assign tps1      = (cfg.ticks_per_second == 32'd0) ? 32'd1 : cfg.ticks_per_second;
  assign e_ext     = LHS_W'(elapsed_r);
  assign pass      = lhs_r >= LHS_W'(rhs_r);
  assign update    = !chk_r && cfg.sensors_enabled;

  always_comb begin
    filter_nxt = filter_r;
    run_nxt    = run_r;
    start_nxt  = start_r;
    latch_nxt  = latch_r;
    queued_nxt = queued_r;
    raised     = 1'b0;
    if (chk_r) begin
      if (latch_r && ({1'b0, cur_r} < win_r)) begin
        latch_nxt = 1'b0;
      end
    end else if (!cfg.sensors_enabled) begin
      run_nxt    = 1'b0;
      queued_nxt = 1'b0;
    end else begin
      filter_nxt = fcand_r;
      if (above_r) begin
        if (!run_r) begin
          run_nxt   = 1'b1;
          start_nxt = now_r;
        end
        if (pass) begin
          if (!latch_r && cfg.homing_done) begin
            latch_nxt = 1'b1;
            raised    = 1'b1;
          end
          queued_nxt = 1'b1;
        end else begin
          queued_nxt = 1'b0;
        end
      end else begin
        run_nxt    = 1'b0;
        queued_nxt = 1'b0;
      end
    end
  end

  assign fout     = update ? fcand_r : filter_r;
  assign fout_int = sat_int(fout);
  assign out_word = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_r <= 32'd0;
      run_r    <= 1'b0;
      start_r  <= '0;
      latch_r  <= 1'b0;
      queued_r <= 1'b0;
    end else if (cmd.commit) begin
      filter_r <= filter_nxt;
      run_r    <= run_nxt;
      start_r  <= start_nxt;
      latch_r  <= latch_nxt;
      queued_r <= queued_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      chk_r  <= in_chk;
      cur_r  <= in_cur;
      now_r  <= in_now;
      fbp_r  <= 48'(COEF_A1) * 48'(filter_r);
      bx_r   <= 27'(COEF_B0) * 27'(in_cur);
      prod_r <= 24'(cfg.limit_ma) * 24'(cfg.window_percent);
    end
    if (cmd.add) begin
      win_r   <= (win_q[17:16] != 2'd0) ? {WIN_W{1'b1}} : win_q[WIN_W-1:0];
      fcand_r <= (y_sum[33:32] != 2'd0) ? 32'hFFFF_FFFF : y_sum[31:0];
    end
    if (cmd.timing) begin
      above_r   <= update && ({1'b0, fcand_int} > win_r);
      elapsed_r <= run_r ? (now_r - start_r) : '0;
      rhs_r     <= (RHS_W'(cfg.timeout_ms) + RHS_W'(1)) * RHS_W'(tps1);
    end
    if (cmd.scale) begin
      lhs_r <= (e_ext << 10) - (e_ext << 4) - (e_ext << 3);
    end
    if (cmd.commit) begin
      out_r <= {5'd0, queued_nxt, latch_nxt, raised, above_r, win_r, fout_int};
    end
  end

  a_raise_sets_latch: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && raised |=> latch_r && out_r[33])
    else $error("raised fault not latched");

  a_homing_gate: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && !latch_r && latch_nxt |-> cfg.homing_done)
    else $error("fault latched before homing");

  a_check_keeps_filter: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && chk_r |=> $stable(filter_r) && $stable(run_r) && $stable(queued_r))
    else $error("recovery check disturbed filter or timer");

endmodule

`default_nettype wire

[rtl/core/overcurrent_fault_detector.sv]
// top level of the overcurrent fault detector
// a word accepted in idle passes through the add, time, scale and done states before out_tvalid rises
// a new word is accepted only in idle, after the result of the previous word has been committed
// the controller sequences the multiply, add, timer, scale and compare steps one state at a time
// a held result does not block the next accept; the block stalls only when a second result is due
// reset (rst_n low, synchronous) clears filter, timer, fault latch and configuration registers to defaults
`timescale 1ns / 1ps
`default_nettype none

module overcurrent_fault_detector (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // current_ma[14:0], now_ticks[62:15], zero pad
  input  wire logic        in_tuser,   // cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // filtered_ma[14:0], window_ma[30:15], above_window[31],
                                       // fault_raised[32], fault_active[33], fault_queued[34]
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import ocfd_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;

  ocfd_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  ocfd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  ocfd_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .cmd      (cmd),
    .in_chk   (in_tuser),
    .in_cur   (in_tdata[CUR_W-1:0]),
    .in_now   (in_tdata[CUR_W +: TIME_W]),
    .out_word (out_tdata)
  );

endmodule

`default_nettype wire
